FILE: rtl/core/tdpt_pkg.sv
`default_nettype none
package tdpt_pkg;

  localparam int PRIME_TABLE_DEPTH = 4096;
  localparam int TBL_AW = $clog2(PRIME_TABLE_DEPTH);
  localparam int CNT_W = $clog2(PRIME_TABLE_DEPTH + 1);
  localparam int VAL_W = 16;
  localparam int CAND_W = 32;
  localparam int SQ_W = 2 * VAL_W;
  localparam int DIV_CW = $clog2(CAND_W);

  localparam logic [VAL_W-1:0] FIRST_PRIME = VAL_W'(2);
  localparam logic [VAL_W-1:0] SECOND_PRIME = VAL_W'(3);
  localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(2);

endpackage
`default_nettype wire

FILE: rtl/core/trial_division_prime_test.sv
`default_nettype none
// Primality test by trial division against a table of known primes (4096 x 16-bit
// single-port-write RAM, reads registered) that grows as larger divisors are
// found prime. A candidate is taken when start is high and busy is low; one
// result beat follows on out_valid/out_verdict for a single cycle and must be
// taken then, since there is no backpressure. Candidates below 3 are answered
// straight from idle. Each stored prime tried as a divisor takes a table read,
// squaring, a compare and a bit-serial remainder; each further integer tried
// beyond the table is squared, compared and divided into the candidate, and
// while the table has room it is then checked against the stored primes the
// same way and appended if none divides it. The compare ends a walk once the
// divisor's square exceeds the value under test. The table needs no clearing
// pass: a fill count marks valid entries.
module trial_division_prime_test
  import tdpt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [CAND_W-1:0] in_candidate,
  output logic                          out_valid,
  output logic                          out_verdict
);

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_SQ, S_A_CMP, S_A_DIV,
    S_B_INIT, S_B_LAST, S_B_SQ, S_B_CMP, S_B_DIV,
    S_C_RD, S_C_SQ, S_C_CMP, S_C_DIV, S_APPEND
  } state_t;

  state_t state_r, state_nxt;

  logic [CAND_W-2:0] n_r, n_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [VAL_W-1:0]  i_r, i_nxt;
  logic [VAL_W-1:0]  p_r, p_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic              prime_r, prime_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_verdict_r, out_verdict_nxt;

  logic [CAND_W-1:0] dvd_r, dvd_nxt;
  logic [VAL_W-1:0]  dvs_r, dvs_nxt;
  logic [VAL_W-1:0]  rem_r, rem_nxt;
  logic [DIV_CW-1:0] dcnt_r, dcnt_nxt;

  logic [VAL_W-1:0] mem [PRIME_TABLE_DEPTH];
  logic [TBL_AW-1:0] rd_addr, rd_addr_r;
  logic [VAL_W-1:0]  rd_data_r;
  logic              mem_we;
  logic [VAL_W-1:0]  tbl_val;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  k_inc;

  logic [VAL_W:0]    div_shift;
  logic              div_ge;
  logic [VAL_W-1:0]  rem_step;
  logic              div_last;
  logic              rem_zero;

  logic [VAL_W-1:0]  mul_op;
  logic [SQ_W-1:0]   mul_res;

  assign cnt_m1 = count_r - CNT_W'(1);
  assign k_inc  = k_r + CNT_W'(1);
  assign rd_addr = (state_r == S_B_INIT) ? cnt_m1[TBL_AW-1:0] : k_r[TBL_AW-1:0];
  assign mem_we  = (state_r == S_APPEND);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[TBL_AW-1:0]] <= i_r;
    end
    rd_data_r <= mem[rd_addr];
    rd_addr_r <= rd_addr;
  end

  always_comb begin
    if (rd_addr_r == TBL_AW'(0)) begin
      tbl_val = FIRST_PRIME;
    end else if (rd_addr_r == TBL_AW'(1)) begin
      tbl_val = SECOND_PRIME;
    end else begin
      tbl_val = rd_data_r;
    end
  end

  assign div_shift = {rem_r, dvd_r[CAND_W-1]};
  assign div_ge    = (div_shift >= {1'b0, dvs_r});
  assign rem_step  = div_ge ? VAL_W'(div_shift - {1'b0, dvs_r}) : div_shift[VAL_W-1:0];
  assign div_last  = (dcnt_r == DIV_CW'(CAND_W - 1));
  assign rem_zero  = (rem_step == '0);

  assign mul_op  = (state_r == S_B_SQ) ? i_r : tbl_val;
  assign mul_res = mul_op * mul_op;

  always_comb begin
    state_nxt       = state_r;
    n_nxt           = n_r;
    count_nxt       = count_r;
    k_nxt           = k_r;
    i_nxt           = i_r;
    p_nxt           = p_r;
    sq_nxt          = sq_r;
    prime_nxt       = prime_r;
    out_valid_nxt   = 1'b0;
    out_verdict_nxt = out_verdict_r;
    dvd_nxt         = dvd_r << 1;
    dvs_nxt         = dvs_r;
    rem_nxt         = rem_step;
    dcnt_nxt        = dcnt_r + DIV_CW'(1);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          n_nxt = in_candidate[CAND_W-2:0];
          k_nxt = '0;
          if (in_candidate < 2) begin
            out_valid_nxt   = 1'b1;
            out_verdict_nxt = 1'b0;
          end else if (in_candidate == 2) begin
            out_valid_nxt   = 1'b1;
            out_verdict_nxt = 1'b1;
          end else begin
            state_nxt = S_A_RD;
          end
        end
      end
      S_A_RD: begin
        state_nxt = S_A_SQ;
      end
      S_A_SQ: begin
        p_nxt     = tbl_val;
        sq_nxt    = mul_res;
        state_nxt = S_A_CMP;
      end
      S_A_CMP: begin
        if (sq_r > SQ_W'(n_r)) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          dvd_nxt   = CAND_W'(n_r);
          dvs_nxt   = p_r;
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = S_A_DIV;
        end
      end
      S_A_DIV: begin
        if (div_last) begin
          if (rem_zero) begin
            out_valid_nxt   = 1'b1;
            out_verdict_nxt = 1'b0;
            state_nxt       = S_IDLE;
          end else if (k_inc == count_r) begin
            state_nxt = S_B_INIT;
          end else begin
            k_nxt     = k_inc;
            state_nxt = S_A_RD;
          end
        end
      end
      S_B_INIT: begin
        prime_nxt = 1'b1;
        state_nxt = S_B_LAST;
      end
      S_B_LAST: begin
        i_nxt     = tbl_val + VAL_W'(1);
        state_nxt = S_B_SQ;
      end
      S_B_SQ: begin
        sq_nxt    = mul_res;
        state_nxt = S_B_CMP;
      end
      S_B_CMP: begin
        if (sq_r > SQ_W'(n_r)) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = prime_r;
          state_nxt       = S_IDLE;
        end else begin
          dvd_nxt   = CAND_W'(n_r);
          dvs_nxt   = i_r;
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = S_B_DIV;
        end
      end
      S_B_DIV: begin
        if (div_last) begin
          if (rem_zero) begin
            prime_nxt = 1'b0;
          end
          if (count_r < CNT_W'(PRIME_TABLE_DEPTH)) begin
            k_nxt     = '0;
            state_nxt = S_C_RD;
          end else begin
            i_nxt     = i_r + VAL_W'(1);
            state_nxt = S_B_SQ;
          end
        end
      end
      S_C_RD: begin
        state_nxt = S_C_SQ;
      end
      S_C_SQ: begin
        p_nxt     = tbl_val;
        sq_nxt    = mul_res;
        state_nxt = S_C_CMP;
      end
      S_C_CMP: begin
        if (sq_r > SQ_W'(i_r)) begin
          state_nxt = S_APPEND;
        end else begin
          dvd_nxt   = CAND_W'(i_r);
          dvs_nxt   = p_r;
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = S_C_DIV;
        end
      end
      S_C_DIV: begin
        if (div_last) begin
          if (rem_zero) begin
            i_nxt     = i_r + VAL_W'(1);
            state_nxt = S_B_SQ;
          end else if (k_inc == count_r) begin
            state_nxt = S_APPEND;
          end else begin
            k_nxt     = k_inc;
            state_nxt = S_C_RD;
          end
        end
      end
      S_APPEND: begin
        count_nxt = count_r + CNT_W'(1);
        i_nxt     = i_r + VAL_W'(1);
        state_nxt = S_B_SQ;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= RESET_COUNT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r           <= n_nxt;
    k_r           <= k_nxt;
    i_r           <= i_nxt;
    p_r           <= p_nxt;
    sq_r          <= sq_nxt;
    prime_r       <= prime_nxt;
    out_verdict_r <= out_verdict_nxt;
    dvd_r         <= dvd_nxt;
    dvs_r         <= dvs_nxt;
    rem_r         <= rem_nxt;
    dcnt_r        <= dcnt_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule
`default_nettype wire

FILE: sim/trial_division_prime_test_tb.sv
`timescale 1ns / 100ps

module trial_division_prime_test_tb;
  import tdpt_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int TAIL_CYCLES = 64;
  localparam int RANDOM_BEATS = 266;
  localparam int unsigned STALL_LIMIT = 64_000_000;

  typedef struct packed {
    logic signed [CAND_W-1:0] candidate;
    logic                     verdict;
  } pending_verdict_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [CAND_W-1:0] in_candidate = '0;
  logic                     out_valid;
  logic                     out_verdict;

  bit [VAL_W-1:0]   prime_table [PRIME_TABLE_DEPTH];
  int unsigned      prime_count;
  pending_verdict_t expected_verdicts [$];
  int unsigned      mismatch_count = 0;
  int unsigned      idle_pct = 33;

  trial_division_prime_test uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_candidate(in_candidate),
    .out_valid   (out_valid),
    .out_verdict (out_verdict)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  function automatic bit listed_prime(input longint unsigned v);
    longint unsigned p;
    for (int k = 0; k < prime_count; k++) begin
      p = prime_table[k];
      if (p * p > v) return 1'b1;
      if (v % p == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit primality_of(input logic signed [CAND_W-1:0] cand);
    longint unsigned n;
    longint unsigned p;
    longint unsigned i;
    bit verdict;
    if (cand < 2) return 1'b0;
    if (cand == 2) return 1'b1;
    n = {32'd0, cand};
    for (int k = 0; k < prime_count; k++) begin
      p = prime_table[k];
      if (p * p > n) return 1'b1;
      if (n % p == 0) return 1'b0;
    end
    verdict = 1'b1;
    for (i = longint'(prime_table[prime_count - 1]) + 1; i * i <= n; i++) begin
      if (n % i == 0) verdict = 1'b0;
      // grow the table only while it has room
      if (prime_count < PRIME_TABLE_DEPTH && listed_prime(i)) begin
        prime_table[prime_count] = i[VAL_W-1:0];
        prime_count++;
      end
    end
    return verdict;
  endfunction

  task automatic send_candidate(input logic signed [CAND_W-1:0] value);
    pending_verdict_t entry;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      in_candidate <= $urandom();
      @(posedge clk);
    end
    start <= 1'b1;
    in_candidate <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    entry.candidate = value;
    entry.verdict = primality_of(value);
    expected_verdicts.push_back(entry);
  endtask

  task automatic wait_for_verdicts();
    start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    pending_verdict_t head;
    if (rst_n && out_valid) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending, verdict=%b",
                                  out_verdict));
      end else begin
        head = expected_verdicts.pop_front();
        if (out_verdict !== head.verdict) begin
          report_mismatch($sformatf("candidate %0d: verdict=%b, expected %b",
                                    head.candidate, out_verdict, head.verdict));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("[%0t] watchdog: no beat for %0d cycles", $time, STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic test_below_two();
    send_candidate(32'sh8000_0000);
    send_candidate(-32'sd1);
    send_candidate($urandom() | 32'h8000_0000);
    send_candidate(32'sd0);
    send_candidate(32'sd1);
    send_candidate(32'sd2);
  endtask

  task automatic test_table_hits();
    send_candidate(32'sd3);
    send_candidate(32'sd4);
    send_candidate(32'sd9);
    send_candidate(32'sd25);
    send_candidate(32'sd49);
    send_candidate(32'sd5);
    send_candidate(32'sd7);
    send_candidate(32'sd121);
    send_candidate(32'sd11);
  endtask

  task automatic test_wider_values();
    send_candidate(32'sd65521);
    send_candidate(32'sd65535);
    send_candidate(32'sd65536);
    send_candidate(32'sd1000003);
    send_candidate(32'sd999999);
  endtask

  task automatic test_random_mix();
    int unsigned sel;
    logic signed [CAND_W-1:0] value;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 90) idle_pct = 0;
      if (n == 170) begin
        wait_for_verdicts();
        idle_pct = 33;
      end
      sel = $urandom_range(0, 99);
      if (sel < 10) value = $urandom() | 32'h8000_0000;
      else if (sel < 20) value = $urandom_range(0, 64);
      else if (sel < 60) value = $urandom_range(3, 4095);
      else if (sel < 85) value = $urandom_range(4096, 65535);
      else if (sel < 90) value = $urandom_range(65536, 1 << 20);
      else value = 3 * $urandom_range(1, 715827882);
      send_candidate(value);
    end
  endtask

  task automatic test_table_full();
    wait_for_verdicts();
    send_candidate(32'sh7FFF_FFFF);
    send_candidate(32'sd2147117569);
    send_candidate(32'sd2147483646);
    send_candidate(32'sd97);
  endtask

  initial begin
    prime_table[0] = FIRST_PRIME;
    prime_table[1] = SECOND_PRIME;
    prime_count = RESET_COUNT;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_below_two();
    test_table_hits();
    wait_for_verdicts();
    test_wider_values();
    test_random_mix();
    test_table_full();
    wait_for_verdicts();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/tdpt_pkg.sv
rtl/core/trial_division_prime_test.sv
sim/trial_division_prime_test_tb.sv
